FILE: hw/rtl/dtq_pkg.sv
// Package for the deadline timer queue: table size, field widths, entry layout,
// request and response codes, and the saturating re-arm add.
// No dependencies.
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int SLOTS        = 32;
  localparam int SLOT_W       = 5;
  localparam int CNT_W        = 6;
  localparam int TIME_W       = 63;
  localparam int INTV_W       = 40;
  localparam int TAG_W        = 16;
  localparam int KIND_W       = 3;
  localparam int REQ_W        = 2;
  localparam int MIN_DELAY_US = 100;

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EXPIRE = 2'd2;

  localparam logic [KIND_W-1:0] RESP_ADDED   = 3'd0;
  localparam logic [KIND_W-1:0] RESP_CANCEL  = 3'd1;
  localparam logic [KIND_W-1:0] RESP_EXPIRED = 3'd2;
  localparam logic [KIND_W-1:0] RESP_NONE    = 3'd3;
  localparam logic [KIND_W-1:0] RESP_FULL    = 3'd4;

  // One table entry as stored in the timer memory.
  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [INTV_W-1:0] interval;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Re-arm time: now plus interval, saturated at the largest time value.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [INTV_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {{(TIME_W+1-INTV_W){1'b0}}, b};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/dtq_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
`timescale 1ns / 1ps

module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/deadline_timer_queue_top.sv
// Top level of the deadline timer queue: request control, live bits, scan
// engine and result register around the timer entry memory.
// Depends on dtq_pkg and dtq_ram.
`timescale 1ns / 1ps

// The timer table lives in a 32-entry memory with one read port, and every
// add, cancel or expire is served by sweeping that memory one entry per cycle.
// An add, a cancel, or an expire that finds nothing goes from transfer to result
// through one sweep of 32 reads, the read latency and a finishing state. An expire
// that emits timers runs one more sweep for each timer, picking each in deadline
// order. One request is handled at a time; the next request may be transferred
// while the last result still waits on the output. Request code 3 is dropped with
// no result.
module deadline_timer_queue_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dtq_pkg::REQ_W-1:0]   req_type,
  input  logic [dtq_pkg::TIME_W-1:0]  deadline_us,
  input  logic [dtq_pkg::INTV_W-1:0]  interval_us,
  input  logic [dtq_pkg::SLOT_W-1:0]  handle_slot,
  input  logic [dtq_pkg::TAG_W-1:0]   handle_tag,
  input  logic [dtq_pkg::TIME_W-1:0]  now_us,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dtq_pkg::KIND_W-1:0]  resp_kind,
  output logic [dtq_pkg::SLOT_W-1:0]  timer_slot,
  output logic [dtq_pkg::TAG_W-1:0]   timer_tag,
  output logic                        found,
  output logic                        earliest_changed,
  output logic                        next_valid,
  output logic [dtq_pkg::TIME_W-1:0]  next_deadline_us,
  output logic [dtq_pkg::TIME_W-1:0]  arm_delay_us,
  output logic                        last
);
  import dtq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DONE = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state;
  logic [SLOTS-1:0]  live;
  logic [TAG_W-1:0]  tag_counter;

  // Captured request.
  logic [REQ_W-1:0]  req_kind;
  logic [TIME_W-1:0] req_deadline;
  logic [INTV_W-1:0] req_interval;
  logic [SLOT_W-1:0] req_slot;
  logic [TAG_W-1:0]  req_tag;
  logic [TIME_W-1:0] req_now;

  // Sweep engine.
  logic [CNT_W-1:0]  scan_idx;
  logic              rd_vld;
  logic [SLOT_W-1:0] rd_idx;
  entry_t            rd_data;

  // Accumulators.
  logic              acc_valid;
  logic [TIME_W-1:0] acc_min;
  logic              earliest;
  logic              hit;
  logic [SLOTS-1:0]  cand;
  logic              best_vld;
  logic [TIME_W-1:0] best_d;
  logic [SLOT_W-1:0] best_idx;
  logic [INTV_W-1:0] best_int;
  logic [TAG_W-1:0]  best_tag;

  // Memory write port.
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;

  logic              out_ok;
  logic              out_load;
  logic              scanning;
  logic              scan_last;
  logic              contrib_v;
  logic [TIME_W-1:0] contrib_d;
  logic              free_v;
  logic [SLOT_W-1:0] free_slot;
  logic              fin_v;
  logic [TIME_W-1:0] fin_d;
  logic [TIME_W-1:0] fin_delay;
  logic [SLOTS-1:0]  cand_left;

  assign in_stall  = (state != S_IDLE);
  assign out_ok    = !out_valid || !out_stall;
  assign out_load  = out_ok && ((state == S_DONE) || (state == S_EMIT));
  assign scanning  = (state == S_SCAN) || (state == S_PICK);
  assign scan_last = rd_vld && (rd_idx == SLOT_W'(SLOTS - 1));
  assign cand_left = cand & ~(SLOTS'(1) << best_idx);

  dtq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx[SLOT_W-1:0]),
    .rdata (rd_data)
  );

  // Lowest free slot.
  always_comb begin
    free_v    = 1'b0;
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_v    = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  // What the entry now read contributes to the earliest remaining deadline.
  always_comb begin
    contrib_v = 1'b0;
    contrib_d = rd_data.deadline;
    if (rd_vld && live[rd_idx]) begin
      unique case (req_kind)
        REQ_ADD: begin
          contrib_v = 1'b1;
        end
        REQ_CANCEL: begin
          contrib_v = !((rd_idx == req_slot) && (rd_data.tag == req_tag));
        end
        default: begin
          contrib_v = 1'b1;
          if (rd_data.deadline <= req_now) begin
            contrib_v = (rd_data.interval != '0);
            contrib_d = sat_add(req_now, rd_data.interval);
          end
        end
      endcase
    end
  end

  // Earliest deadline after the request, and the delay until it, at least MIN_DELAY_US.
  always_comb begin
    fin_v = acc_valid;
    fin_d = acc_min;
    if (req_kind == REQ_ADD && free_v && (!acc_valid || req_deadline < acc_min)) begin
      fin_v = 1'b1;
      fin_d = req_deadline;
    end
    fin_delay = (fin_d > req_now) ? fin_d - req_now : '0;
    if (fin_delay < TIME_W'(MIN_DELAY_US)) begin
      fin_delay = TIME_W'(MIN_DELAY_US);
    end
    if (!fin_v) begin
      fin_d     = '0;
      fin_delay = '0;
    end
  end

  // Memory writes: a new timer on add, a re-armed deadline on expire.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_slot;
    ram_wdata = '{deadline: req_deadline, interval: req_interval, tag: tag_counter};
    if (state == S_DONE && out_ok && req_kind == REQ_ADD && free_v) begin
      ram_we = 1'b1;
    end else if (state == S_EMIT && out_ok && best_int != '0) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx;
      ram_wdata = '{deadline: sat_add(req_now, best_int), interval: best_int,
                    tag: best_tag};
    end
  end

  // Sweep address and read tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= scanning && (scan_idx < CNT_W'(SLOTS));
    end
    rd_idx <= scan_idx[SLOT_W-1:0];
  end

  // Request control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      live        <= '0;
      tag_counter <= '0;
      out_valid   <= 1'b0;
      scan_idx    <= '0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      if (scanning && scan_idx < CNT_W'(SLOTS)) begin
        scan_idx <= scan_idx + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_kind     <= req_type;
            req_deadline <= deadline_us;
            req_interval <= interval_us;
            req_slot     <= handle_slot;
            req_tag      <= handle_tag;
            req_now      <= now_us;
            scan_idx     <= '0;
            acc_valid    <= 1'b0;
            acc_min      <= '0;
            earliest     <= 1'b1;
            hit          <= 1'b0;
            cand         <= '0;
            if (req_type == REQ_ADD || req_type == REQ_CANCEL || req_type == REQ_EXPIRE) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (contrib_v && (!acc_valid || contrib_d < acc_min)) begin
            acc_valid <= 1'b1;
            acc_min   <= contrib_d;
          end
          if (rd_vld && live[rd_idx]) begin
            if (req_kind == REQ_ADD && !(req_deadline < rd_data.deadline)) begin
              earliest <= 1'b0;
            end
            if (req_kind == REQ_CANCEL && rd_idx == req_slot && rd_data.tag == req_tag) begin
              hit <= 1'b1;
            end
            if (req_kind == REQ_EXPIRE && rd_data.deadline <= req_now) begin
              cand[rd_idx] <= 1'b1;
            end
          end
          if (scan_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ok) begin
            next_valid       <= fin_v;
            next_deadline_us <= fin_d;
            arm_delay_us     <= fin_delay;
            last             <= 1'b1;
            unique case (req_kind)
              REQ_ADD: begin
                found     <= 1'b0;
                out_valid <= 1'b1;
                state     <= S_IDLE;
                if (free_v) begin
                  resp_kind        <= RESP_ADDED;
                  timer_slot       <= free_slot;
                  timer_tag        <= tag_counter;
                  earliest_changed <= earliest;
                  live[free_slot]  <= 1'b1;
                  tag_counter      <= tag_counter + 1'b1;
                end else begin
                  resp_kind        <= RESP_FULL;
                  timer_slot       <= '0;
                  timer_tag        <= '0;
                  earliest_changed <= 1'b0;
                end
              end
              REQ_CANCEL: begin
                resp_kind        <= RESP_CANCEL;
                timer_slot       <= '0;
                timer_tag        <= '0;
                earliest_changed <= 1'b0;
                found            <= hit;
                out_valid        <= 1'b1;
                state            <= S_IDLE;
                if (hit) begin
                  live[req_slot] <= 1'b0;
                end
              end
              default: begin
                resp_kind        <= RESP_NONE;
                timer_slot       <= '0;
                timer_tag        <= '0;
                found            <= 1'b0;
                earliest_changed <= 1'b0;
                if (cand != '0) begin
                  out_valid <= 1'b0;
                  scan_idx  <= '0;
                  best_vld  <= 1'b0;
                  state     <= S_PICK;
                end else begin
                  out_valid <= 1'b1;
                  state     <= S_IDLE;
                end
              end
            endcase
          end
        end
        S_PICK: begin
          // Earliest remaining candidate; ties go to the lower slot.
          if (rd_vld && cand[rd_idx] && (!best_vld || rd_data.deadline < best_d)) begin
            best_vld <= 1'b1;
            best_d   <= rd_data.deadline;
            best_idx <= rd_idx;
            best_int <= rd_data.interval;
            best_tag <= rd_data.tag;
          end
          if (scan_last) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ok) begin
            out_valid        <= 1'b1;
            resp_kind        <= RESP_EXPIRED;
            timer_slot       <= best_idx;
            timer_tag        <= best_tag;
            found            <= 1'b0;
            earliest_changed <= 1'b0;
            next_valid       <= fin_v;
            next_deadline_us <= fin_d;
            arm_delay_us     <= fin_delay;
            last             <= (cand_left == '0);
            cand             <= cand_left;
            if (best_int == '0) begin
              live[best_idx] <= 1'b0;
            end
            if (cand_left == '0) begin
              state <= S_IDLE;
            end else begin
              scan_idx <= '0;
              best_vld <= 1'b0;
              state    <= S_PICK;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Writes never land while a sweep is reading the memory.
  assert property (@(posedge clk) disable iff (rst) !(ram_we && rd_vld))
    else $error("memory write during a sweep read");

  // Expire candidates are always live timers.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK || state == S_EMIT) |-> ((cand & ~live) == '0))
    else $error("expire candidate is not live");

  // A timer is emitted only while candidates remain.
  assert property (@(posedge clk) disable iff (rst) (state == S_EMIT) |-> (cand != '0))
    else $error("emit with no candidate left");

endmodule

FILE: dv/deadline_timer_queue_top_tb.sv
// Testbench for deadline_timer_queue_top: directed and random timer requests
// with random handshake gaps, checked by a scoreboard class against predicted results.
// Depends on dtq_pkg and the deadline_timer_queue_top RTL.
`timescale 1ns / 1ps

module deadline_timer_queue_top_tb;
  import dtq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam bit [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam bit [INTV_W-1:0] INTV_MAX = {INTV_W{1'b1}};

  // One response as seen on the output ports.
  typedef struct {
    bit [KIND_W-1:0] kind;
    bit [SLOT_W-1:0] slot;
    bit [TAG_W-1:0]  tag;
    bit              found;
    bit              earliest;
    bit              nvalid;
    bit [TIME_W-1:0] ndead;
    bit [TIME_W-1:0] delay;
    bit              last;
  } resp_t;

  // Shadow timer table that predicts responses and compares them.
  class timer_scoreboard;
    bit              live[SLOTS];
    bit [TIME_W-1:0] dl[SLOTS];
    bit [INTV_W-1:0] iv[SLOTS];
    bit [TAG_W-1:0]  tg[SLOTS];
    bit [TAG_W-1:0]  tag_next;
    resp_t           pending_resps[$];
    int              errors;
    int              checked;
    int              full_seen;
    int              max_burst;

    function int live_count();
      int n;
      n = 0;
      foreach (live[i]) if (live[i]) n++;
      return n;
    endfunction

    function resp_t blank(bit [KIND_W-1:0] kind);
      resp_t r;
      r = '{default: 0};
      r.kind = kind;
      return r;
    endfunction

    // Predict the responses of one accepted request.
    function void note_request(bit [REQ_W-1:0] req, bit [TIME_W-1:0] deadline,
                               bit [INTV_W-1:0] interval, bit [SLOT_W-1:0] hslot,
                               bit [TAG_W-1:0] htag, bit [TIME_W-1:0] now);
      resp_t           batch[$];
      resp_t           r;
      int              free_slot;
      int              bi;
      bit              earliest;
      bit [SLOTS-1:0]  cand;
      bit [SLOTS-1:0]  picked;
      bit [TIME_W:0]   sum;
      bit              nv;
      bit [TIME_W-1:0] best;
      bit [TIME_W-1:0] dly;
      if (req == REQ_UNUSED) return;
      if (req == REQ_ADD) begin
        free_slot = -1;
        earliest = 1;
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i]) begin
            if (!(deadline < dl[i])) earliest = 0;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (free_slot < 0) begin
          batch.push_back(blank(RESP_FULL));
          full_seen++;
        end else begin
          live[free_slot] = 1;
          dl[free_slot] = deadline;
          iv[free_slot] = interval;
          tg[free_slot] = tag_next;
          r = blank(RESP_ADDED);
          r.slot = SLOT_W'(free_slot);
          r.tag = tag_next;
          r.earliest = earliest;
          batch.push_back(r);
          tag_next++;
        end
      end else if (req == REQ_CANCEL) begin
        r = blank(RESP_CANCEL);
        if (live[hslot] && tg[hslot] == htag) begin
          live[hslot] = 0;
          r.found = 1;
        end
        batch.push_back(r);
      end else begin
        cand = '0;
        picked = '0;
        for (int i = 0; i < SLOTS; i++) if (live[i] && dl[i] <= now) cand[i] = 1;
        // Earliest deadline first; ties go to the lower slot.
        while (cand != 0) begin
          bi = -1;
          for (int i = 0; i < SLOTS; i++)
            if (cand[i] && (bi < 0 || dl[i] < dl[bi])) bi = i;
          cand[bi] = 0;
          picked[bi] = 1;
          r = blank(RESP_EXPIRED);
          r.slot = SLOT_W'(bi);
          r.tag = tg[bi];
          batch.push_back(r);
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (picked[i]) begin
            if (iv[i] != 0) begin
              sum = {1'b0, now} + iv[i];
              dl[i] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            end else begin
              live[i] = 0;
            end
          end
        end
        if (batch.size() == 0) batch.push_back(blank(RESP_NONE));
        if (batch.size() > max_burst) max_burst = batch.size();
      end
      // Next deadline and clamped delay go on every response.
      nv = 0;
      best = 0;
      dly = 0;
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && (!nv || dl[i] < best)) begin
          best = dl[i];
          nv = 1;
        end
      if (nv) begin
        dly = (best > now) ? best - now : 0;
        if (dly < TIME_W'(MIN_DELAY_US)) dly = TIME_W'(MIN_DELAY_US);
      end
      foreach (batch[k]) begin
        batch[k].nvalid = nv;
        batch[k].ndead = best;
        batch[k].delay = dly;
        batch[k].last = (k == batch.size() - 1);
        pending_resps.push_back(batch[k]);
      end
    endfunction

    function void cmp(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        errors++;
      end
    endfunction

    // Compare one accepted response with the oldest prediction.
    function void check_result(resp_t a);
      resp_t e;
      if (pending_resps.size() == 0) begin
        $error("response transfer with nothing predicted: kind %0d", a.kind);
        errors++;
        return;
      end
      e = pending_resps.pop_front();
      checked++;
      cmp("resp_kind", e.kind, a.kind);
      cmp("timer_slot", e.slot, a.slot);
      cmp("timer_tag", e.tag, a.tag);
      cmp("found", e.found, a.found);
      cmp("earliest_changed", e.earliest, a.earliest);
      cmp("next_valid", e.nvalid, a.nvalid);
      cmp("next_deadline_us", e.ndead, a.ndead);
      cmp("arm_delay_us", e.delay, a.delay);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [REQ_W-1:0]  req_type;
  logic [TIME_W-1:0] deadline_us;
  logic [INTV_W-1:0] interval_us;
  logic [SLOT_W-1:0] handle_slot;
  logic [TAG_W-1:0]  handle_tag;
  logic [TIME_W-1:0] now_us;
  logic              out_valid;
  logic              out_stall;
  logic [KIND_W-1:0] resp_kind;
  logic [SLOT_W-1:0] timer_slot;
  logic [TAG_W-1:0]  timer_tag;
  logic              found;
  logic              earliest_changed;
  logic              next_valid;
  logic [TIME_W-1:0] next_deadline_us;
  logic [TIME_W-1:0] arm_delay_us;
  logic              last;

  timer_scoreboard sb;
  bit              no_gaps;
  bit              long_hold;
  bit [TIME_W-1:0] cur_time;
  int              sent;

  deadline_timer_queue_top u_dut (.*);

  // Clock generation.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watch both channels for transfers at the rising edge.
  always @(posedge clk) begin
    resp_t a;
    if (!rst && in_valid && !in_stall)
      sb.note_request(req_type, deadline_us, interval_us, handle_slot, handle_tag, now_us);
    if (!rst && out_valid && !out_stall) begin
      a.kind = resp_kind;
      a.slot = timer_slot;
      a.tag = timer_tag;
      a.found = found;
      a.earliest = earliest_changed;
      a.nvalid = next_valid;
      a.ndead = next_deadline_us;
      a.delay = arm_delay_us;
      a.last = last;
      sb.check_result(a);
    end
  end

  // Response side: random stall before each transfer, one long hold-off on request.
  initial begin
    int n;
    out_stall = 1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 19);
      if (long_hold) begin
        n = 400;
        long_hold = 0;
      end
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offer one request and hold it until it is transferred.
  task automatic send(bit [REQ_W-1:0] req, bit [TIME_W-1:0] dl, bit [INTV_W-1:0] iv,
                      bit [SLOT_W-1:0] hs, bit [TAG_W-1:0] ht, bit [TIME_W-1:0] now);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req_type <= req;
    deadline_us <= dl;
    interval_us <= iv;
    handle_slot <= hs;
    handle_tag <= ht;
    now_us <= now;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (req != REQ_UNUSED) sent++;
  endtask

  // Stop offering and wait until every predicted response has arrived.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending_resps.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic bit [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic bit [INTV_W-1:0] rand_intv();
    return INTV_W'({$urandom, $urandom});
  endfunction

  // Random request with mostly meaningful content.
  task automatic send_random();
    int              w;
    int              s;
    bit [TIME_W-1:0] dl;
    bit [INTV_W-1:0] iv;
    bit [TIME_W-1:0] now;
    w = $urandom_range(0, 99);
    now = ($urandom_range(0, 9) == 0) ? rand_time() : cur_time;
    if (w < 45) begin
      dl = ($urandom_range(0, 6) == 0) ? rand_time() : cur_time + $urandom_range(0, 5000);
      case ($urandom_range(0, 19)) inside
        [0:9]:   iv = 0;
        [10:16]: iv = INTV_W'($urandom_range(1, 3000));
        default: iv = rand_intv();
      endcase
      send(REQ_ADD, dl, iv, SLOT_W'($urandom), TAG_W'($urandom), now);
    end else if (w < 65) begin
      s = $urandom_range(0, SLOTS - 1);
      w = $urandom_range(0, 19);
      if (w < 14 && sb.live_count() != 0) begin
        while (!sb.live[s]) s = $urandom_range(0, SLOTS - 1);
        send(REQ_CANCEL, rand_time(), rand_intv(), SLOT_W'(s), sb.tg[s] ^ (w >= 11), now);
      end else begin
        send(REQ_CANCEL, rand_time(), rand_intv(), SLOT_W'(s), TAG_W'($urandom), now);
      end
    end else if (w < 97) begin
      cur_time += $urandom_range(0, 3000);
      send(REQ_EXPIRE, rand_time(), rand_intv(), SLOT_W'($urandom), TAG_W'($urandom),
           ($urandom_range(0, 15) == 0) ? rand_time() : cur_time);
    end else begin
      send(REQ_UNUSED, rand_time(), rand_intv(), SLOT_W'($urandom), TAG_W'($urandom),
           rand_time());
    end
  endtask

  // Main stimulus.
  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    req_type = REQ_ADD;
    deadline_us = 0;
    interval_us = 0;
    handle_slot = 0;
    handle_tag = 0;
    now_us = 0;
    no_gaps = 0;
    long_hold = 0;
    sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty table, extremes, tie on add, cancel misses, saturating re-arm.
    send(REQ_EXPIRE, 0, 0, 0, 0, 0);
    send(REQ_CANCEL, 0, 0, 0, 0, 0);
    send(REQ_ADD, TIME_MAX, 0, 0, 0, 0);
    send(REQ_ADD, 0, INTV_MAX, 0, 0, 0);
    send(REQ_ADD, 0, 5, 0, 0, 0);
    send(REQ_CANCEL, 0, 0, 1, 0, 0);
    send(REQ_CANCEL, 0, 0, 31, 16'hffff, 0);
    send(REQ_CANCEL, 0, 0, 2, 2, 0);
    send(REQ_UNUSED, TIME_MAX, INTV_MAX, 31, 16'hffff, TIME_MAX);
    send(REQ_EXPIRE, 0, 0, 0, 0, 10);
    send(REQ_EXPIRE, 0, 0, 0, 0, TIME_MAX);
    send(REQ_CANCEL, 0, 0, 1, 1, 0);
    send(REQ_ADD, 50, 0, 0, 0, 0);
    send(REQ_ADD, 1000, 0, 0, 0, 2000);
    send(REQ_EXPIRE, 0, 0, 0, 0, 5000);
    drain();
    cur_time = 10000;

    // Random traffic with a full table, a long output hold-off and a drained pause.
    while (sent < 215) begin
      if (sent == 80) begin
        // Fill the table, overflow it once, then expire every timer at once.
        drain();
        while (sb.live_count() < SLOTS)
          send(REQ_ADD, cur_time + $urandom_range(0, 50), $urandom_range(0, 1) ? 0 : INTV_MAX,
               0, 0, cur_time);
        send(REQ_ADD, rand_time(), rand_intv(), 0, 0, cur_time);
        send(REQ_EXPIRE, 0, 0, 0, 0, TIME_MAX);
        cur_time = TIME_MAX - 200000;
      end
      if (sent == 140) begin
        long_hold = 1;
        no_gaps = 1;
      end
      if (sent == 170) no_gaps = 0;
      if (sent == 190) drain();
      send_random();
    end
    drain();
    repeat (200) @(posedge clk);
    $display("Checked %0d responses from %0d requests; table full seen %0d times,",
             sb.checked, sent, sb.full_seen);
    $display("largest expire burst %0d timers, %0d predictions left over.",
             sb.max_burst, sb.pending_resps.size());
    if (sb.errors == 0 && sb.pending_resps.size() == 0)
      $display("deadline_timer_queue_top_tb: done, clean");
    else
      $display("deadline_timer_queue_top_tb: done, errors");
    $finish;
  end

  // Overall time limit.
  initial begin
    #20ms;
    $display("deadline_timer_queue_top_tb: done, errors");
    $finish;
  end

endmodule

FILE: deadline_timer_queue_top.f
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_ram.sv
hw/rtl/deadline_timer_queue_top.sv
dv/deadline_timer_queue_top_tb.sv
